// ===== design/gtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared types and constants of the GBK text layout and glyph address block.
// ----------------------------------------------------------------------------
package gtl_pkg;

  // Configuration register indexes.
  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_ORIGIN_X     = 3'd0;
  localparam reg_index_t REG_ORIGIN_Y     = 3'd1;
  localparam reg_index_t REG_BOX_WIDTH    = 3'd2;
  localparam reg_index_t REG_BOX_HEIGHT   = 3'd3;
  localparam reg_index_t REG_FONT_SIZE    = 3'd4;
  localparam reg_index_t REG_FONT_BASE    = 3'd5;
  localparam reg_index_t REG_OVERLAY_MODE = 3'd6;

  localparam int CFG_DATA_W = 24;

  // Cell kinds of a draw command.
  typedef logic [1:0] cell_kind_t;
  localparam cell_kind_t KIND_ASCII = 2'd0;
  localparam cell_kind_t KIND_WIDE  = 2'd1;
  localparam cell_kind_t KIND_EMPTY = 2'd2;

  // Byte codes of the GBK stream.
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_CR       = 8'd13;
  localparam logic [7:0] LEAD_THRESH   = 8'h80;
  localparam logic [7:0] LEAD_BASE     = 8'h81;
  localparam logic [7:0] TRAIL_BASE    = 8'h40;
  localparam logic [7:0] TRAIL_GAP     = 8'h7f;
  localparam logic [7:0] TRAIL_BASE_HI = 8'h41;
  localparam logic [7:0] BYTE_INVALID  = 8'hff;

  // Font geometry.
  localparam logic [5:0] WIDE_SIZE      = 6'd32;
  localparam logic [7:0] GLYPH_BYTES    = 8'd128;
  localparam int         GLYPH_SHIFT    = 7;
  localparam logic [7:0] GLYPHS_PER_ROW = 8'd190;
  localparam int         PROD_W         = 15;
  localparam int         CUR_MAX        = 8191;
  localparam int         POS_W          = 13;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic emit;
  } gtl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic has_result;
    logic out_busy;
  } gtl_status_t;

endpackage

// ===== design/gtl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_ctrl
// Sequencer: accept a byte, run the layout step, hand the result to the
// output register.
// ----------------------------------------------------------------------------
module gtl_ctrl
  import gtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gtl_status_t status,
  output gtl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    cmd.emit    = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.has_result ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // Wait until the output register is free or drains this cycle.
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/gtl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtl_datapath
// Configuration registers, cursor and decode state, layout step, address
// computation and the output register.
// ----------------------------------------------------------------------------
module gtl_datapath
  import gtl_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  gtl_cmd_t              cmd,
  output gtl_status_t           status,
  input  logic [7:0]            text_byte,
  input  logic                  string_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cell_kind_t            cell_kind,
  output logic [POS_W-1:0]      pos_x,
  output logic [POS_W-1:0]      pos_y,
  output logic [6:0]            ascii_code,
  output logic [23:0]           glyph_addr,
  output logic [7:0]            glyph_bytes,
  output logic                  transparent
);

  // Cursor width covers both the clamped range and an unclamped origin.
  localparam int CW = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
  localparam int SW = CW + 3;

  function automatic logic [CW-1:0] clamp_cur(input logic signed [SW-1:0] v);
    logic [CW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SW'(CUR_MAX))) begin
      r = CW'(CUR_MAX);
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [COORD_BITS-1:0] origin_x, origin_y, box_width, box_height;
  logic [5:0]            font_size;
  logic [23:0]           font_base_addr;
  logic                  overlay_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      box_width      <= COORD_BITS'(320);
      box_height     <= COORD_BITS'(480);
      font_size      <= WIDE_SIZE;
      font_base_addr <= '0;
      overlay_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORIGIN_X:     origin_x       <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:     origin_y       <= cfg_data[COORD_BITS-1:0];
        REG_BOX_WIDTH:    box_width      <= cfg_data[COORD_BITS-1:0];
        REG_BOX_HEIGHT:   box_height     <= cfg_data[COORD_BITS-1:0];
        REG_FONT_SIZE:    font_size      <= cfg_data[5:0];
        REG_FONT_BASE:    font_base_addr <= cfg_data[23:0];
        REG_OVERLAY_MODE: overlay_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Captured input transaction.
  logic [7:0] byte_q;
  logic       start_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_q  <= text_byte;
      start_q <= string_start;
    end
  end

  // Layout state.
  logic [CW-1:0] cursor_x, cursor_y;
  logic          lead_pending, skip_next, stopped;
  logic [7:0]    lead_value;

  logic [CW-1:0] cursor_x_next, cursor_y_next;
  logic          lead_pending_next, skip_next_next, stopped_next;
  logic [7:0]    lead_value_next;

  // Values after an optional string restart.
  logic [CW-1:0] eff_cx, eff_cy;
  logic          eff_lp, eff_sk, eff_st;
  logic [7:0]    eff_lv;

  logic signed [SW-1:0] cx_s, cy_s, ox_s, oy_s, bw_s, bh_s, size_s, cell_s;
  logic signed [SW-1:0] xw_s, yw_s;
  logic                 wrap, full, bad_code;
  logic                 res_valid;
  cell_kind_t           res_kind;
  logic [7:0]           row, col;

  always_comb begin
    eff_cx = start_q ? CW'(origin_x) : cursor_x;
    eff_cy = start_q ? CW'(origin_y) : cursor_y;
    eff_lp = start_q ? 1'b0 : lead_pending;
    eff_lv = start_q ? 8'h00 : lead_value;
    eff_sk = start_q ? 1'b0 : skip_next;
    eff_st = start_q ? 1'b0 : stopped;

    cx_s   = $signed({3'b000, eff_cx});
    cy_s   = $signed({3'b000, eff_cy});
    ox_s   = $signed(SW'(origin_x));
    oy_s   = $signed(SW'(origin_y));
    bw_s   = $signed(SW'(box_width));
    bh_s   = $signed(SW'(box_height));
    size_s = $signed(SW'(font_size));
    cell_s = eff_lp ? size_s : $signed(SW'(font_size[5:1]));

    // A character that would cross the right edge starts a new line.
    wrap = cx_s > (ox_s + bw_s - cell_s);
    xw_s = wrap ? ox_s : cx_s;
    yw_s = wrap ? (cy_s + size_s) : cy_s;
    full = yw_s > (oy_s + bh_s - size_s);

    bad_code = (font_size != WIDE_SIZE) || (eff_lv < LEAD_BASE) || (byte_q < TRAIL_BASE) ||
               (byte_q == BYTE_INVALID) || (eff_lv == BYTE_INVALID);
    row = eff_lv - LEAD_BASE;
    col = (byte_q < TRAIL_GAP) ? (byte_q - TRAIL_BASE) : (byte_q - TRAIL_BASE_HI);

    cursor_x_next     = eff_cx;
    cursor_y_next     = eff_cy;
    lead_pending_next = eff_lp;
    lead_value_next   = eff_lv;
    skip_next_next    = eff_sk;
    stopped_next      = eff_st;
    res_valid         = 1'b0;
    res_kind          = KIND_ASCII;

    priority if (byte_q == BYTE_NUL) begin
      // A zero byte ends the string wherever it arrives.
      stopped_next      = 1'b1;
      lead_pending_next = 1'b0;
      skip_next_next    = 1'b0;
    end else if (eff_st) begin
    end else if (eff_sk) begin
      skip_next_next = 1'b0;
    end else if (!eff_lp && (byte_q > LEAD_THRESH)) begin
      lead_pending_next = 1'b1;
      lead_value_next   = byte_q;
    end else if (full) begin
      stopped_next      = 1'b1;
      lead_pending_next = 1'b0;
    end else if (eff_lp) begin
      lead_pending_next = 1'b0;
      res_valid         = 1'b1;
      res_kind          = bad_code ? KIND_EMPTY : KIND_WIDE;
      cursor_x_next     = clamp_cur(xw_s + size_s);
      cursor_y_next     = clamp_cur(yw_s);
    end else if (byte_q == BYTE_CR) begin
      cursor_x_next  = clamp_cur(ox_s);
      cursor_y_next  = clamp_cur(yw_s + size_s);
      skip_next_next = 1'b1;
    end else begin
      res_valid     = 1'b1;
      res_kind      = KIND_ASCII;
      cursor_x_next = clamp_cur(xw_s + cell_s);
      cursor_y_next = clamp_cur(yw_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      lead_pending <= 1'b0;
      lead_value   <= '0;
      skip_next    <= 1'b0;
      stopped      <= 1'b0;
    end else if (cmd.exec) begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      lead_pending <= lead_pending_next;
      lead_value   <= lead_value_next;
      skip_next    <= skip_next_next;
      stopped      <= stopped_next;
    end
  end

  // Staging registers: the row product is registered before the address add.
  cell_kind_t         st_kind;
  logic [POS_W-1:0]   st_x, st_y;
  logic [6:0]         st_code;
  logic [PROD_W-1:0]  st_prod;
  logic [7:0]         st_col;
  logic [PROD_W-1:0]  glyph_index;
  logic [23:0]        addr_calc;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_kind <= res_kind;
      st_x    <= xw_s[POS_W-1:0];
      st_y    <= yw_s[POS_W-1:0];
      st_code <= byte_q[6:0];
      st_prod <= PROD_W'(16'(row) * 16'(GLYPHS_PER_ROW));
      st_col  <= col;
    end
  end

  assign glyph_index = st_prod + PROD_W'(st_col);
  assign addr_calc   = 24'({glyph_index, {GLYPH_SHIFT{1'b0}}}) + font_base_addr;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_kind   <= st_kind;
      pos_x       <= st_x;
      pos_y       <= st_y;
      ascii_code  <= (st_kind == KIND_ASCII) ? st_code : 7'd0;
      glyph_addr  <= (st_kind == KIND_WIDE) ? addr_calc : 24'd0;
      glyph_bytes <= (st_kind == KIND_WIDE) ? GLYPH_BYTES : 8'd0;
      transparent <= overlay_mode;
    end
  end

  assign status.has_result = res_valid;
  assign status.out_busy   = out_valid && !out_ready;

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result loaded while output register was stalled");

  // Loading the output register always presents a transaction.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emit did not raise out_valid");

  // A pending lead byte and a skip after CR never coexist.
  a_lead_skip: assert property (@(posedge clk) disable iff (rst)
    !(lead_pending && skip_next))
    else $error("lead_pending and skip_next both set");

  // The step runs only on a captured byte, never in the capture cycle.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> cmd.exec && !cmd.load_in)
    else $error("layout step did not follow byte capture");

endmodule

// ===== design/gbk_text_layout_glyph_addr_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbk_text_layout_glyph_addr_top
// GBK text layout with font flash glyph addressing.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one GBK byte per
//   transaction together with string_start, which restarts the cursor at the
//   box origin and clears the decode flags before that byte. Each character
//   yields at most one draw command on the output channel (out_valid/
//   out_ready): its cell kind, position, ASCII code or flash glyph address.
//   Lead bytes, CR, skipped bytes, a stopped layout or a full box give none.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data; the
//   user must write it only while the block is idle, which the block does
//   not enforce itself. Writes take effect at the next clock edge.
//   Steps: a byte is captured when accepted and laid out in the next
//   cycle. A byte with a result takes a further emit step in which the
//   registered row product is added to the font base and the output
//   register is loaded. A new byte is not accepted until the sequencer
//   has finished these steps for the last one.
//   When the receiver stalls, the result waits in the output register and
//   the next byte is still accepted and laid out; the sequencer then holds
//   in its emit step until the output register is free.
//   Synchronous reset clears the sequencer, the cursor and flags, and loads
//   the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gbk_text_layout_glyph_addr_top
  import gtl_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            text_byte,
  input  logic                  string_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            cell_kind,
  output logic [12:0]           pos_x,
  output logic [12:0]           pos_y,
  output logic [6:0]            ascii_code,
  output logic [23:0]           glyph_addr,
  output logic [7:0]            glyph_bytes,
  output logic                  transparent
);

  // Commands from the sequencer and status back from the datapath.
  gtl_cmd_t    cmd;
  gtl_status_t status;

  gtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the cursor and the output register.
  gtl_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .text_byte    (text_byte),
    .string_start (string_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_kind    (cell_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .ascii_code   (ascii_code),
    .glyph_addr   (glyph_addr),
    .glyph_bytes  (glyph_bytes),
    .transparent  (transparent)
  );

endmodule
